/* hdl/dq_pkg.sv */
// Shared types and constants for the double-ended queue.
// No dependencies; every other file of the block but dq_ram refers to it by scoped names.
package dq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;
  localparam int CMD_W         = 2;
  localparam int ERR_W         = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

endpackage

/* hdl/dq_if.sv */
// Valid/ready channel interfaces for the deque: command in, status out.
// Depends on dq_pkg for the payload widths and types.
interface dq_cmd_if;
  logic                              valid;
  logic                              ready;
  dq_pkg::cmd_t                      cmd;
  logic signed [dq_pkg::DATA_W-1:0]  value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface dq_res_if #(
  parameter int COUNT_W = 5
);
  logic                              valid;
  logic                              ready;
  logic signed [dq_pkg::DATA_W-1:0]  front_value;
  logic signed [dq_pkg::DATA_W-1:0]  back_value;
  logic        [COUNT_W-1:0]         count;
  logic                              is_empty;
  dq_pkg::err_t                      error;

  modport source (output valid, front_value, back_value, count, is_empty, error,
                  input ready);
  modport sink   (input valid, front_value, back_value, count, is_empty, error,
                  output ready);
endinterface

/* hdl/dq_ram.sv */
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

/* hdl/dq_ptr.sv */
// Ring pointer unit: head index, element count, error code, and the slot
// addresses for the write and for the front/back reads. Depends on dq_pkg.
module dq_ptr #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  dq_pkg::cmd_t                       cmd,
  input  logic [dq_pkg::DATA_W-1:0]          value,
  output logic                               wr_en,
  output logic [$clog2(DEPTH)-1:0]           wr_addr,
  output logic [dq_pkg::DATA_W-1:0]          wr_data,
  output logic [$clog2(DEPTH)-1:0]           front_addr,
  output logic [$clog2(DEPTH)-1:0]           back_addr,
  output logic [$clog2(DEPTH+1)-1:0]         count,
  output dq_pkg::err_t                       err
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count_next;
  dq_pkg::err_t  err_next;

  logic          full, empty;
  logic [AW-1:0] head_inc, head_dec;
  logic [SW-1:0] push_sum, back_sum;
  logic [CW-1:0] back_off;
  logic [AW-1:0] push_addr;

  // sums stay below 2*DEPTH, so one conditional subtract wraps them
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= DEPTH_S) ? s - DEPTH_S : s;
    return r[AW-1:0];
  endfunction

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? LAST_IDX : head - 1'b1;
  assign back_off = empty ? '0 : count - 1'b1;
  assign push_sum = SW'(head) + SW'(count);
  assign back_sum = SW'(head) + SW'(back_off);
  assign push_addr = wrap(push_sum);

  assign front_addr = head;
  assign back_addr  = wrap(back_sum);
  assign wr_data    = value;
  assign wr_addr    = (cmd == dq_pkg::CMD_PUSH_FRONT) ? head_dec : push_addr;
  assign wr_en      = load && !full &&
                      (cmd == dq_pkg::CMD_PUSH_BACK || cmd == dq_pkg::CMD_PUSH_FRONT);

  always_comb begin
    head_next  = head;
    count_next = count;
    err_next   = dq_pkg::ERR_OK;
    unique case (cmd)
      dq_pkg::CMD_PUSH_BACK: begin
        if (full) err_next = dq_pkg::ERR_FULL;
        else count_next = count + 1'b1;
      end
      dq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          err_next = dq_pkg::ERR_FULL;
        end else begin
          head_next  = head_dec;
          count_next = count + 1'b1;
        end
      end
      dq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          err_next = dq_pkg::ERR_EMPTY;
        end else begin
          head_next  = head_inc;
          count_next = count - 1'b1;
        end
      end
      dq_pkg::CMD_POP_BACK: begin
        if (empty) err_next = dq_pkg::ERR_EMPTY;
        else count_next = count - 1'b1;
      end
      default: begin
        err_next = dq_pkg::ERR_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      err   <= dq_pkg::ERR_OK;
    end else if (load) begin
      head  <= head_next;
      count <= count_next;
      err   <= err_next;
    end
  end

endmodule

/* hdl/double_ended_queue.sv */
// Bounded double-ended queue on a ring buffer held in a two-read-port RAM.
// Depends on dq_pkg, dq_if (dq_cmd_if, dq_res_if), dq_ptr and dq_ram.
//
//   channel   dir   modport          payload
//   cmd_ch    in    dq_cmd_if.sink   cmd, value
//   res_ch    out   dq_res_if.source front_value, back_value, count, is_empty, error
//
// A command runs through the states in order: the transfer cycle updates
// the pointers and writes the slot, S_READ addresses the front and back slots,
// and S_LOAD catches the registered RAM data into the result register. The
// registered RAM read is what S_READ waits out. A new command is taken as soon as
// the result register is loaded, even while it waits on res_ch.ready; a
// stalled result holds the unit in S_LOAD. Reset (rst, synchronous)
// empties the queue; slot contents are not cleared.
// res_ch must be built with COUNT_W = $clog2(DEPTH + 1).
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  dq_cmd_if.sink          cmd_ch,
  dq_res_if.source        res_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state, state_next;

  logic                        accept, load_res;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr, front_addr, back_addr;
  logic [dq_pkg::DATA_W-1:0]   wr_data, front_data, back_data;
  logic [CW-1:0]               count;
  dq_pkg::err_t                err;

  logic                        res_valid;
  logic [dq_pkg::DATA_W-1:0]   res_front, res_back;
  logic [CW-1:0]               res_count;
  dq_pkg::err_t                res_err;

  assign cmd_ch.ready = (state == S_IDLE);
  assign accept       = cmd_ch.valid && cmd_ch.ready;
  assign load_res     = (state == S_LOAD) && (!res_valid || res_ch.ready);

  dq_ptr #(.DEPTH(DEPTH)) u_ptr (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .cmd        (cmd_ch.cmd),
    .value      (cmd_ch.value),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .front_addr (front_addr),
    .back_addr  (back_addr),
    .count      (count),
    .err        (err)
  );

  dq_ram #(.WIDTH(dq_pkg::DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (front_addr),
    .rd_data_a (front_data),
    .rd_addr_b (back_addr),
    .rd_data_b (back_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_READ;
      S_READ: state_next = S_LOAD;
      S_LOAD: if (load_res) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_res) res_valid <= 1'b1;
      else if (res_ch.ready) res_valid <= 1'b0;
    end
  end

  // payload; empty queue reads as zero at both ends
  always_ff @(posedge clk) begin
    if (load_res) begin
      res_front <= (count == '0) ? '0 : front_data;
      res_back  <= (count == '0) ? '0 : back_data;
      res_count <= count;
      res_err   <= err;
    end
  end

  assign res_ch.valid       = res_valid;
  assign res_ch.front_value = res_front;
  assign res_ch.back_value  = res_back;
  assign res_ch.count       = res_count;
  assign res_ch.is_empty    = (res_count == '0);
  assign res_ch.error       = res_err;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("element count above depth");

  a_full_err: assert property (@(posedge clk) disable iff (rst)
    res_ch.valid && res_ch.error == dq_pkg::ERR_FULL |-> res_ch.count == FULL_CNT)
    else $error("full refusal reported with room left");

  a_empty_err: assert property (@(posedge clk) disable iff (rst)
    res_ch.valid && res_ch.error == dq_pkg::ERR_EMPTY |-> res_ch.is_empty)
    else $error("empty pop reported on a non-empty queue");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_READ && !cmd_ch.ready)
    else $error("command taken while a previous one is in flight");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Testbench for double_ended_queue: directed corner cases, then random command mixes,
// checked against an in-bench ring model. Depends on dq_pkg, dq_if and the RTL.
module tb;

  localparam int QDEPTH  = dq_pkg::DEPTH_DEFAULT;
  localparam int COUNT_W = $clog2(QDEPTH + 1);
  localparam logic signed [dq_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [dq_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [dq_pkg::DATA_W-1:0] front;
    logic signed [dq_pkg::DATA_W-1:0] back;
    logic [COUNT_W-1:0]               fill;
    logic                             empty;
    dq_pkg::err_t                     err;
  } deque_status_t;

  logic clk;
  logic rst;

  dq_cmd_if                      cmd_ch ();
  dq_res_if #(.COUNT_W(COUNT_W)) res_ch ();

  double_ended_queue #(.DEPTH(QDEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .res_ch (res_ch)
  );

  // ring model of the queue
  logic signed [dq_pkg::DATA_W-1:0] ring_slots [QDEPTH];
  int head_pos;
  int fill_level;

  deque_status_t pending_status [$];
  int mismatches = 0;
  int burst_left;

  // receiver stall pattern state
  int stall_mode = 0;
  int stall_mode_left = 0;
  int stall_run = 0;
  int rx_cycle = 0;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic deque_status_t apply_deque_cmd(dq_pkg::cmd_t c,
                                                    logic signed [dq_pkg::DATA_W-1:0] v);
    deque_status_t s;
    s.err   = dq_pkg::ERR_OK;
    s.front = '0;
    s.back  = '0;
    case (c)
      dq_pkg::CMD_PUSH_BACK: begin
        if (fill_level >= QDEPTH) begin
          s.err = dq_pkg::ERR_FULL;
        end else begin
          ring_slots[(head_pos + fill_level) % QDEPTH] = v;
          fill_level++;
        end
      end
      dq_pkg::CMD_PUSH_FRONT: begin
        if (fill_level >= QDEPTH) begin
          s.err = dq_pkg::ERR_FULL;
        end else begin
          head_pos = (head_pos + QDEPTH - 1) % QDEPTH;
          ring_slots[head_pos] = v;
          fill_level++;
        end
      end
      dq_pkg::CMD_POP_FRONT: begin
        if (fill_level == 0) begin
          s.err = dq_pkg::ERR_EMPTY;
        end else begin
          head_pos = (head_pos + 1) % QDEPTH;
          fill_level--;
        end
      end
      default: begin
        if (fill_level == 0) s.err = dq_pkg::ERR_EMPTY;
        else fill_level--;
      end
    endcase
    if (fill_level != 0) begin
      s.front = ring_slots[head_pos];
      s.back  = ring_slots[(head_pos + fill_level - 1) % QDEPTH];
    end
    s.fill  = COUNT_W'(fill_level);
    s.empty = (fill_level == 0);
    return s;
  endfunction

  // Called at a rising edge; returns at the transfer edge or after a burst-end gap.
  task automatic send_cmd(dq_pkg::cmd_t c, logic signed [dq_pkg::DATA_W-1:0] v);
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd   <= c;
    cmd_ch.value <= v;
    do @(posedge clk); while (!cmd_ch.ready);
    pending_status.push_back(apply_deque_cmd(c, v));
    if (burst_left == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // always moves past the edge it was called at
  task automatic hold_until_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  function automatic logic signed [dq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic dq_pkg::cmd_t pick_push();
    return $urandom_range(0, 1) ? dq_pkg::CMD_PUSH_BACK : dq_pkg::CMD_PUSH_FRONT;
  endfunction

  function automatic dq_pkg::cmd_t pick_pop();
    return $urandom_range(0, 1) ? dq_pkg::CMD_POP_FRONT : dq_pkg::CMD_POP_BACK;
  endfunction

  // empty pops, extreme values, single-element pops at both ends
  task automatic test_corner_cases();
    send_cmd(dq_pkg::CMD_POP_FRONT, VAL_MAX);
    send_cmd(dq_pkg::CMD_POP_BACK, VAL_MIN);
    send_cmd(dq_pkg::CMD_PUSH_BACK, VAL_MAX);
    send_cmd(dq_pkg::CMD_PUSH_FRONT, VAL_MIN);
    send_cmd(dq_pkg::CMD_POP_FRONT, '0);
    send_cmd(dq_pkg::CMD_POP_BACK, '1);
    send_cmd(dq_pkg::CMD_PUSH_FRONT, '1);
    send_cmd(dq_pkg::CMD_POP_FRONT, '0);
  endtask

  // fill from empty to full, then both pushes get refused
  task automatic test_fill_to_full();
    for (int i = 0; i < QDEPTH; i++) begin
      send_cmd((i % 2) ? dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_BACK,
               (i % 2) ? 32'sh5555_5555 ^ i : 32'shaaaa_aaaa ^ i);
    end
    send_cmd(dq_pkg::CMD_PUSH_BACK, VAL_MAX);
    send_cmd(dq_pkg::CMD_PUSH_FRONT, VAL_MIN);
  endtask

  // phases biased toward filling, draining or balanced traffic
  task automatic test_random_mix(int n_items);
    int sent;
    int phase_left;
    int bias;
    int push_pct;
    sent = 0;
    phase_left = 0;
    bias = 0;
    while (sent < n_items) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(8, 40);
        bias = $urandom_range(0, 2);
      end
      push_pct = (bias == 0) ? 80 : (bias == 1) ? 20 : 50;
      if ($urandom_range(0, 99) < push_pct) send_cmd(pick_push(), pick_value());
      else send_cmd(pick_pop(), pick_value());
      phase_left--;
      sent++;
      if (sent == n_items / 2) hold_until_drained();
    end
  endtask

  // receiver: free-running, random, periodic or long stalls, mode changes now and then
  always @(posedge clk) begin
    rx_cycle++;
    if (stall_mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(50, 200);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= ($urandom_range(0, 9) >= 3);
      2: res_ch.ready <= (rx_cycle % 4 != 0);
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          res_ch.ready <= 1'b0;
        end else begin
          if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(2, 10);
          res_ch.ready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    deque_status_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: front=%0d back=%0d count=%0d empty=%0b err=%0d",
                   res_ch.front_value, res_ch.back_value, res_ch.count,
                   res_ch.is_empty, res_ch.error);
      end else begin
        want = pending_status.pop_front();
        if (res_ch.front_value !== want.front || res_ch.back_value !== want.back ||
            res_ch.count !== want.fill || res_ch.is_empty !== want.empty ||
            res_ch.error !== want.err) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: expected front=%0d back=%0d count=%0d empty=%0b err=%0d",
                     $realtime, want.front, want.back, want.fill, want.empty, want.err);
            $display("  got front=%0d back=%0d count=%0d empty=%0b err=%0d",
                     res_ch.front_value, res_ch.back_value, res_ch.count,
                     res_ch.is_empty, res_ch.error);
          end
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    head_pos = 0;
    fill_level = 0;
    burst_left = 0;
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.cmd   <= dq_pkg::CMD_PUSH_BACK;
    cmd_ch.value <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_corner_cases();
    hold_until_drained();
    test_fill_to_full();
    hold_until_drained();
    test_random_mix(1024);

    hold_until_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/dq_pkg.sv
hdl/dq_if.sv
hdl/dq_ram.sv
hdl/dq_ptr.sv
hdl/double_ended_queue.sv
tb/sv/tb.sv
